// ----- hw/rtl/bitmap_slot_allocator_defines.svh -----
// assertion macros for the slot allocator
`ifndef BITMAP_SLOT_ALLOCATOR_DEFINES_SVH
`define BITMAP_SLOT_ALLOCATOR_DEFINES_SVH

// checked on every rising edge outside reset
`define BSA_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define BSA_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/bsa_pkg.sv -----
`timescale 1ns / 1ps

package bsa_pkg;

  // fixed field widths
  localparam int MODE_W      = 2;
  localparam int IDX_W       = 11;
  localparam int CFG_W       = 11;
  localparam int STATUS_W    = 3;
  localparam int SLOT_OUT_W  = 10;
  localparam int COUNT_OUT_W = 11;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 24;

  // parameter defaults
  localparam int MAX_SLOTS_DEF = 1024;
  localparam int WORD_BITS_DEF = 32;

  localparam logic [CFG_W-1:0] SLOT_COUNT_RST = 11'd1024;

  // request modes
  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_NEXT  = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_BAD_INDEX = 3'd2,
    STAT_UNUSED    = 3'd3,
    STAT_NONE      = 3'd4,
    STAT_EMPTY     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_BASE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

// ----- hw/rtl/bitmap_slot_allocator.sv -----
// bitmap first-fit slot allocator, one request at a time
// path, input beat to result beat: ST_IDLE, ST_DIV, ST_BASE, then ST_SCAN once per bitmap
//   word scanned, then ST_DONE and the output register; ST_IDLE goes straight to ST_DONE
//   when decode already settles the answer (full, empty, bad index, search past the count)
// a new request is taken only once ST_DONE has loaded the last result into the output register, which can wait on
//   out_tready; allocate and next scan up to MAX_SLOTS/WORD_BITS words, free reads one word
`timescale 1ns / 1ps
`include "bitmap_slot_allocator_defines.svh"

module bitmap_slot_allocator #(
  parameter int MAX_SLOTS = bsa_pkg::MAX_SLOTS_DEF,
  parameter int WORD_BITS = bsa_pkg::WORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration: slot_count
  input  logic                           cfg_wr_en,
  input  logic [bsa_pkg::CFG_W-1:0]      cfg_wr_data,
  // request beats
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [bsa_pkg::IN_DATA_W-1:0]  in_tdata,   // [10:0] slot_index, [15:11] zero
  input  logic [bsa_pkg::MODE_W-1:0]     in_tuser,   // [1:0] mode
  // result beats
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [bsa_pkg::OUT_DATA_W-1:0] out_tdata,  // [9:0] result_slot, [20:10] use_count,
                                                     // [23:21] zero
  output logic [bsa_pkg::STATUS_W-1:0]   out_tuser   // [2:0] status
);

  import bsa_pkg::*;

  // bitmap geometry
  localparam int WORD_COUNT = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BO_W       = $clog2(WORD_BITS);
  localparam int POS_W      = $clog2(MAX_SLOTS + 1);
  // signed width wide enough for index, count and slot_count compares
  localparam int CW         = ((POS_W > IDX_W) ? POS_W : IDX_W) + 2;
  // signed width for bit window offsets
  localparam int DW         = POS_W + 2;
  // word index of a slot by reciprocal multiply: floor(x * MUL_C / 2^MUL_S)
  localparam int MUL_S      = POS_W + BO_W;
  localparam int MUL_C      = ((2 ** MUL_S) + WORD_BITS - 1) / WORD_BITS;
  localparam int PW         = POS_W + POS_W + 2;

  // state and working registers
  state_t                   state_r, state_nxt;
  logic [WA_W-1:0]          clr_r, clr_nxt;
  logic [MODE_W-1:0]        mode_r, mode_nxt;
  logic [POS_W-1:0]         lo_r, lo_nxt;      // first slot of the search window
  logic [POS_W-1:0]         hi_r, hi_nxt;      // one past the last slot of the window
  logic [WA_W-1:0]          word_r, word_nxt;
  logic [POS_W-1:0]         base_r, base_nxt;  // first slot of word_r
  logic [POS_W-1:0]         used_r, used_nxt;
  status_t                  res_status_r, res_status_nxt;
  logic [SLOT_OUT_W-1:0]    res_slot_r, res_slot_nxt;
  logic [CFG_W-1:0]         slot_count_r;

  // output register
  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic [SLOT_OUT_W-1:0]    out_slot_r, out_slot_nxt;
  logic [COUNT_OUT_W-1:0]   out_count_r, out_count_nxt;

  // bitmap memory
  logic [WORD_BITS-1:0]     occ_mem [WORD_COUNT];
  logic [WORD_BITS-1:0]     rd_data_r;
  logic [WA_W-1:0]          rd_addr;
  logic                     mem_we;
  logic [WA_W-1:0]          wr_addr;
  logic [WORD_BITS-1:0]     wr_data;

  // request decode
  logic signed [IDX_W-1:0]  idx_s;
  logic signed [CW-1:0]     idx_w, cnt_w, used_w, start_w;
  logic                     in_beat, out_free;

  // word scan
  logic signed [DW-1:0]     rel_lo, rel_hi;
  logic [WORD_BITS-1:0]     window, cand, hit;
  logic [BO_W-1:0]          hit_bit;
  logic                     hit_any;
  logic [POS_W-1:0]         hit_slot;
  logic [WORD_BITS-1:0]     hit_mask;
  logic [POS_W:0]           next_base;
  logic [PW-1:0]            div_prod;

  assign idx_s   = $signed(in_tdata[IDX_W-1:0]);
  assign idx_w   = CW'(idx_s);
  // active count saturates at the bitmap size
  assign cnt_w   = (CW'(slot_count_r) > CW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(slot_count_r);
  assign used_w  = CW'(used_r);
  // next starts at slot 0 for any negative index
  assign start_w = (idx_w < 0) ? '0 : idx_w + CW'(1);

  assign in_tready = (state_r == ST_IDLE);
  assign in_beat   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign div_prod  = PW'(lo_r) * PW'(MUL_C);
  assign next_base = (POS_W + 1)'(base_r) + (POS_W + 1)'(WORD_BITS);

  // window of candidate bits in the current word
  assign rel_lo = $signed({2'b00, lo_r}) - $signed({2'b00, base_r});
  assign rel_hi = $signed({2'b00, hi_r}) - $signed({2'b00, base_r});

  always_comb begin
    logic signed [DW-1:0] bpos;
    for (int b = 0; b < WORD_BITS; b++) begin
      bpos      = DW'(b);
      window[b] = (bpos >= rel_lo) && (bpos < rel_hi);
    end
  end

  // allocate hunts for a clear bit, free and next for a set one
  assign cand = (mode_r == MODE_ALLOC) ? ~rd_data_r : rd_data_r;
  assign hit  = cand & window;

  // lowest set bit of the hit vector
  always_comb begin
    hit_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (hit[b]) begin
        hit_bit = BO_W'(b);
      end
    end
  end

  assign hit_any  = |hit;
  assign hit_slot = base_r + POS_W'(hit_bit);
  assign hit_mask = WORD_BITS'(1) << hit_bit;

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    mode_nxt       = mode_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    word_nxt       = word_r;
    base_nxt       = base_r;
    used_nxt       = used_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_count_nxt  = out_count_r;
    rd_addr        = word_r;
    mem_we         = 1'b0;
    wr_addr        = word_r;
    wr_data        = rd_data_r;

    unique case (state_r)
      ST_CLEAR: begin
        // zero one bitmap word per cycle after reset
        mem_we  = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        clr_nxt = clr_r + WA_W'(1);
        if (clr_r == WA_W'(WORD_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_beat) begin
          mode_nxt     = in_tuser;
          res_slot_nxt = '0;
          state_nxt    = ST_DONE;
          priority case (in_tuser)
            MODE_ALLOC: begin
              if (used_w >= cnt_w) begin
                res_status_nxt = STAT_FULL;
              end else begin
                lo_nxt    = '0;
                hi_nxt    = POS_W'(cnt_w);
                state_nxt = ST_DIV;
              end
            end
            MODE_FREE: begin
              if (used_r == '0) begin
                res_status_nxt = STAT_EMPTY;
              end else if (idx_w < 0 || idx_w >= cnt_w) begin
                res_status_nxt = STAT_BAD_INDEX;
              end else begin
                lo_nxt    = POS_W'(idx_w);
                hi_nxt    = POS_W'(idx_w + CW'(1));
                state_nxt = ST_DIV;
              end
            end
            MODE_NEXT: begin
              if (start_w >= cnt_w) begin
                res_status_nxt = STAT_NONE;
              end else begin
                lo_nxt    = POS_W'(start_w);
                hi_nxt    = POS_W'(cnt_w);
                state_nxt = ST_DIV;
              end
            end
            default: begin
              res_status_nxt = STAT_BAD_INDEX;
            end
          endcase
        end
      end

      ST_DIV: begin
        word_nxt  = WA_W'(div_prod >> MUL_S);
        state_nxt = ST_BASE;
      end

      ST_BASE: begin
        // first word read goes out here
        base_nxt  = POS_W'(word_r * WORD_BITS);
        state_nxt = ST_SCAN;
      end

      ST_SCAN: begin
        if (hit_any) begin
          res_status_nxt = STAT_OK;
          res_slot_nxt   = SLOT_OUT_W'(hit_slot);
          state_nxt      = ST_DONE;
          if (mode_r == MODE_ALLOC) begin
            mem_we   = 1'b1;
            wr_data  = rd_data_r | hit_mask;
            used_nxt = used_r + POS_W'(1);
          end else if (mode_r == MODE_FREE) begin
            mem_we   = 1'b1;
            wr_data  = rd_data_r & ~hit_mask;
            used_nxt = used_r - POS_W'(1);
          end
        end else if (next_base < (POS_W + 1)'(hi_r)) begin
          // window goes on into the next word
          word_nxt = word_r + WA_W'(1);
          base_nxt = POS_W'(next_base);
          rd_addr  = word_r + WA_W'(1);
        end else begin
          state_nxt = ST_DONE;
          if (mode_r == MODE_ALLOC) begin
            res_status_nxt = STAT_FULL;
          end else if (mode_r == MODE_FREE) begin
            res_status_nxt = STAT_UNUSED;
          end else begin
            res_status_nxt = STAT_NONE;
          end
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_count_nxt  = COUNT_OUT_W'(used_r);
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // bitmap memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      occ_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= occ_mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      used_r       <= '0;
      out_valid_r  <= 1'b0;
      slot_count_r <= SLOT_COUNT_RST;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        slot_count_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    word_r       <= word_nxt;
    base_r       <= base_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {(OUT_DATA_W - COUNT_OUT_W - SLOT_OUT_W)'(0), out_count_r, out_slot_r};

  // reset always restarts the clearing pass
  `BSA_CHECK_ALWAYS(a_reset_clears, !rst_n |=> state_r == ST_CLEAR, "reset did not start clear")
  // use count only moves together with a bitmap write from the scan
  `BSA_CHECK(a_count_with_write,
    $past(rst_n) && used_r != $past(used_r) |-> $past(mem_we) && $past(state_r) == ST_SCAN,
    "use count changed without bitmap update")
  // a scan either carries on or finishes
  `BSA_CHECK(a_scan_exit, state_r == ST_SCAN |=> state_r == ST_SCAN || state_r == ST_DONE,
    "scan left to wrong state")
  // a new result is only ever loaded at the end of a request
  `BSA_CHECK(a_result_from_done, $past(rst_n) && $rose(out_valid_r) |-> $past(state_r) == ST_DONE,
    "result beat raised outside done")
  // the use count never passes the bitmap size
  `BSA_CHECK(a_count_bound, used_r <= POS_W'(MAX_SLOTS), "use count above bitmap size")

endmodule
